// File: rtl/rfps_pkg.sv
`timescale 1ns / 1ps
package rfps_pkg;

	localparam logic [15:0] PYRO_PULSE_TICKS    = 16'd100;
	localparam logic [31:0] MAIN_FAILSAFE_TICKS = 32'd2000;
	localparam logic [31:0] BARO_TIMEOUT_TICKS  = 32'd50;
	localparam bit          DUAL_DEPLOY         = 1'b0;

	localparam int MIDQ_DEPTH = 4;
	localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
	localparam int CFG_DW     = 21;

	localparam logic [2:0] REG_LAUNCH_ACCEL   = 3'd0;
	localparam logic [2:0] REG_LAUNCH_TICKS   = 3'd1;
	localparam logic [2:0] REG_APOGEE_DROP    = 3'd2;
	localparam logic [2:0] REG_APOGEE_TICKS   = 3'd3;
	localparam logic [2:0] REG_APOGEE_MIN     = 3'd4;
	localparam logic [2:0] REG_MAIN_HEIGHT    = 3'd5;
	localparam logic [2:0] REG_LANDED_HEIGHT  = 3'd6;
	localparam logic [2:0] REG_LANDED_TICKS   = 3'd7;

	typedef struct packed {
		logic        [14:0] launch_accel_mg;
		logic        [7:0]  launch_ticks_needed;
		logic        [16:0] apogee_drop_cm;
		logic        [7:0]  apogee_ticks_needed;
		logic        [15:0] apogee_min_ticks;
		logic        [19:0] main_height_cm;
		logic signed [20:0] landed_height_cm;
		logic        [19:0] landed_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [24:0] height_cm;
		logic               baro_ok;
		logic               arm_request;
		logic               accel_hi;
		logic               below_main;
		logic               below_landed;
	} front_item_t;

	typedef struct packed {
		logic [2:0]         flight_phase;
		logic               drogue_pyro;
		logic               main_pyro;
		logic               phase_changed;
		logic signed [24:0] peak_height_cm;
	} result_t;

endpackage

// File: rtl/rfps_front.sv
`timescale 1ns / 1ps
module rfps_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [15:0]        accel_x_mg,
	input  logic signed [15:0]        accel_y_mg,
	input  logic signed [15:0]        accel_z_mg,
	input  logic signed [24:0]        height_cm,
	input  logic                      baro_ok,
	input  logic                      arm_request,
	input  rfps_pkg::cfg_t            cfg,
	output logic                      out_valid,
	output rfps_pkg::front_item_t     out_item,
	output logic [1:0]                inflight
);
	import rfps_pkg::*;

	logic signed [31:0] px, py, pz;
	logic        [29:0] thr;
	logic               bmain, bland;
	logic        [32:0] mag;

	logic               v_s1;
	logic        [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic        [29:0] thr_s1;
	logic signed [24:0] h_s1;
	logic               baro_s1, arm_s1, bmain_s1, bland_s1;

	logic               v_s2;
	front_item_t        item_s2;

	always_comb begin
		px    = accel_x_mg * accel_x_mg;
		py    = accel_y_mg * accel_y_mg;
		pz    = accel_z_mg * accel_z_mg;
		thr   = cfg.launch_accel_mg * cfg.launch_accel_mg;
		bmain = $signed({height_cm[24], height_cm}) < $signed({6'd0, cfg.main_height_cm});
		bland = height_cm < $signed({{4{cfg.landed_height_cm[20]}}, cfg.landed_height_cm});
		mag   = {2'd0, sqx_s1} + {2'd0, sqy_s1} + {2'd0, sqz_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1   <= px[30:0];
		sqy_s1   <= py[30:0];
		sqz_s1   <= pz[30:0];
		thr_s1   <= thr;
		h_s1     <= height_cm;
		baro_s1  <= baro_ok;
		arm_s1   <= arm_request;
		bmain_s1 <= bmain;
		bland_s1 <= bland;

		item_s2.height_cm    <= h_s1;
		item_s2.baro_ok      <= baro_s1;
		item_s2.arm_request  <= arm_s1;
		item_s2.accel_hi     <= mag > {3'd0, thr_s1};
		item_s2.below_main   <= bmain_s1;
		item_s2.below_landed <= bland_s1;
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;
	assign inflight  = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

// File: rtl/rfps_midq.sv
`timescale 1ns / 1ps
module rfps_midq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_valid,
	input  rfps_pkg::front_item_t         wr_item,
	input  logic                          rd_take,
	output logic                          rd_valid,
	output rfps_pkg::front_item_t         rd_item,
	output logic [rfps_pkg::MIDQ_AW:0]    count
);
	import rfps_pkg::*;

	front_item_t        mem_q [MIDQ_DEPTH];
	logic [MIDQ_AW-1:0] wp_q, rp_q;
	logic [MIDQ_AW:0]   cnt_q;
	logic               do_rd;

	assign rd_valid = cnt_q != '0;
	assign do_rd    = rd_take && rd_valid;
	assign rd_item  = mem_q[rp_q];
	assign count    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_valid)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (wr_valid && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr_valid && do_rd)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid)
			mem_q[wp_q] <= wr_item;
	end

endmodule

// File: rtl/rfps_back.sv
`timescale 1ns / 1ps
module rfps_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  rfps_pkg::front_item_t     in_item,
	output logic                      in_take,
	input  rfps_pkg::cfg_t            cfg,
	output logic                      empty,
	input  logic                      pop,
	output rfps_pkg::result_t         result
);
	import rfps_pkg::*;

	typedef enum logic [2:0] {
		PH_PRELAUNCH = 3'd0,
		PH_ARMED     = 3'd1,
		PH_ASCENT    = 3'd2,
		PH_DROGUE    = 3'd3,
		PH_MAIN      = 3'd4,
		PH_LANDED    = 3'd5
	} phase_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] c);
		return (c != 8'hff) ? c + 8'd1 : 8'hff;
	endfunction

	phase_t             phase_q, phase_n;
	logic [7:0]         lrun_q, lrun_n, arun_q, arun_n;
	logic [31:0]        tick_q, tick_n, toff_q, toff_n, apo_q, apo_n, lgb_q, lgb_n;
	logic signed [24:0] peak_q, peak_n;
	logic [15:0]        dpl_q, dpl_n, mpl_q, mpl_n;

	result_t            oq_q [2];
	logic               owp_q, orp_q;
	logic [1:0]         ocnt_q;
	logic               do_pop;

	logic signed [24:0] h;
	logic               stale, past_min, below_peak, deploy;
	logic [7:0]         arun_inc, lrun_inc;
	logic [31:0]        since_apo;
	result_t            res;

	assign in_take = in_valid && (ocnt_q != 2'd2);
	assign empty   = ocnt_q == 2'd0;
	assign do_pop  = pop && !empty;
	assign result  = oq_q[orp_q];

	always_comb begin
		h          = in_item.height_cm;
		tick_n     = tick_q + 32'd1;
		lgb_n      = in_item.baro_ok ? tick_n : lgb_q;
		dpl_n      = (dpl_q != '0) ? dpl_q - 16'd1 : dpl_q;
		mpl_n      = (mpl_q != '0) ? mpl_q - 16'd1 : mpl_q;
		stale      = (tick_n - lgb_n) > BARO_TIMEOUT_TICKS;
		past_min   = (tick_n - toff_q) > {16'd0, cfg.apogee_min_ticks};
		since_apo  = tick_n - apo_q;
		phase_n    = phase_q;
		lrun_n     = lrun_q;
		arun_n     = arun_q;
		toff_n     = toff_q;
		apo_n      = apo_q;
		peak_n     = (h > peak_q) ? h : peak_q;
		below_peak = $signed({h[24], h}) <
			($signed({peak_n[24], peak_n}) - $signed({9'd0, cfg.apogee_drop_cm}));
		arun_inc   = sat_inc(arun_q);
		lrun_inc   = sat_inc(lrun_q);
		deploy     = 1'b0;
		if (phase_q != PH_ASCENT)
			peak_n = peak_q;

		unique case (phase_q)
			PH_PRELAUNCH: begin
				if (in_item.arm_request) begin
					phase_n = PH_ARMED;
					lrun_n  = '0;
				end
			end
			PH_ARMED: begin
				if (!in_item.arm_request) begin
					phase_n = PH_PRELAUNCH;
					lrun_n  = '0;
					arun_n  = '0;
				end else if (in_item.accel_hi) begin
					lrun_n = lrun_inc;
					if (lrun_inc > cfg.launch_ticks_needed) begin
						toff_n  = tick_n;
						peak_n  = '0;
						phase_n = PH_ASCENT;
					end
				end else begin
					lrun_n = '0;
				end
			end
			PH_ASCENT: begin
				if (below_peak && past_min) begin
					arun_n = arun_inc;
					if (arun_inc > cfg.apogee_ticks_needed)
						deploy = 1'b1;
				end else begin
					arun_n = '0;
				end
				if (stale && past_min)
					deploy = 1'b1;
				if (deploy) begin
					apo_n = tick_n;
					if (DUAL_DEPLOY) begin
						phase_n = PH_DROGUE;
						dpl_n   = PYRO_PULSE_TICKS;
					end else begin
						phase_n = PH_MAIN;
						mpl_n   = PYRO_PULSE_TICKS;
					end
				end
			end
			PH_DROGUE: begin
				if (in_item.below_main || (stale && since_apo > MAIN_FAILSAFE_TICKS)) begin
					phase_n = PH_MAIN;
					mpl_n   = PYRO_PULSE_TICKS;
				end
			end
			PH_MAIN: begin
				if (in_item.below_landed || since_apo > {12'd0, cfg.landed_ticks})
					phase_n = PH_LANDED;
			end
			default: ;
		endcase

		res.flight_phase   = phase_n;
		res.drogue_pyro    = dpl_n != '0;
		res.main_pyro      = mpl_n != '0;
		res.phase_changed  = phase_n != phase_q;
		res.peak_height_cm = peak_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRELAUNCH;
			lrun_q  <= '0;
			arun_q  <= '0;
			tick_q  <= '0;
			toff_q  <= '0;
			apo_q   <= '0;
			lgb_q   <= '0;
			peak_q  <= '0;
			dpl_q   <= '0;
			mpl_q   <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			if (in_take) begin
				phase_q <= phase_n;
				lrun_q  <= lrun_n;
				arun_q  <= arun_n;
				tick_q  <= tick_n;
				toff_q  <= toff_n;
				apo_q   <= apo_n;
				lgb_q   <= lgb_n;
				peak_q  <= peak_n;
				dpl_q   <= dpl_n;
				mpl_q   <= mpl_n;
				owp_q   <= ~owp_q;
			end
			if (do_pop)
				orp_q <= ~orp_q;
			if (in_take && !do_pop)
				ocnt_q <= ocnt_q + 2'd1;
			else if (!in_take && do_pop)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			oq_q[owp_q] <= res;
	end

endmodule

// File: rtl/rocket_flight_phase_sequencer_top.sv
`timescale 1ns / 1ps
// Flight phase sequencer, one item per 10 ms tick. Sustains one item per clock cycle
// while full stays low; an accepted item passes, in order, the first front stage,
// the second front stage for the magnitude compare and the middle queue, and its
// result then enters the two-entry result queue on the output side.
// full follows the middle queue level plus the items still in the front stages;
// with the result side stalled the block holds up to six items before full rises.
// Configuration writes take effect at once and are meant for an idle block.
module rocket_flight_phase_sequencer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    accel_x_mg,
	input  logic signed [15:0]    accel_y_mg,
	input  logic signed [15:0]    accel_z_mg,
	input  logic signed [24:0]    height_cm,
	input  logic                  baro_ok,
	input  logic                  arm_request,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            flight_phase,
	output logic                  drogue_pyro,
	output logic                  main_pyro,
	output logic                  phase_changed,
	output logic signed [24:0]    peak_height_cm,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [rfps_pkg::CFG_DW-1:0] wr_data
);
	import rfps_pkg::*;

	cfg_t               cfg_q;
	logic               acc;
	logic               f_valid, m_valid, m_take;
	front_item_t        f_item, m_item;
	logic [1:0]         inflight;
	logic [MIDQ_AW:0]   midq_cnt;
	logic [MIDQ_AW+1:0] occ;
	result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.launch_accel_mg     <= 15'd3000;
			cfg_q.launch_ticks_needed <= 8'd5;
			cfg_q.apogee_drop_cm      <= 17'd200;
			cfg_q.apogee_ticks_needed <= 8'd10;
			cfg_q.apogee_min_ticks    <= 16'd300;
			cfg_q.main_height_cm      <= 20'd15000;
			cfg_q.landed_height_cm    <= 21'sd1000;
			cfg_q.landed_ticks        <= 20'd30000;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LAUNCH_ACCEL:  cfg_q.launch_accel_mg     <= wr_data[14:0];
				REG_LAUNCH_TICKS:  cfg_q.launch_ticks_needed <= wr_data[7:0];
				REG_APOGEE_DROP:   cfg_q.apogee_drop_cm      <= wr_data[16:0];
				REG_APOGEE_TICKS:  cfg_q.apogee_ticks_needed <= wr_data[7:0];
				REG_APOGEE_MIN:    cfg_q.apogee_min_ticks    <= wr_data[15:0];
				REG_MAIN_HEIGHT:   cfg_q.main_height_cm      <= wr_data[19:0];
				REG_LANDED_HEIGHT: cfg_q.landed_height_cm    <= $signed(wr_data[20:0]);
				REG_LANDED_TICKS:  cfg_q.landed_ticks        <= wr_data[19:0];
				default: ;
			endcase
		end
	end

	assign occ  = {1'b0, midq_cnt} + (MIDQ_AW+2)'(inflight);
	assign full = occ >= (MIDQ_AW+2)'(MIDQ_DEPTH);
	assign acc  = push && !full;

	rfps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (acc),
		.accel_x_mg  (accel_x_mg),
		.accel_y_mg  (accel_y_mg),
		.accel_z_mg  (accel_z_mg),
		.height_cm   (height_cm),
		.baro_ok     (baro_ok),
		.arm_request (arm_request),
		.cfg         (cfg_q),
		.out_valid   (f_valid),
		.out_item    (f_item),
		.inflight    (inflight)
	);

	rfps_midq u_midq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_item  (f_item),
		.rd_take  (m_take),
		.rd_valid (m_valid),
		.rd_item  (m_item),
		.count    (midq_cnt)
	);

	rfps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (m_valid),
		.in_item  (m_item),
		.in_take  (m_take),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop      (pop),
		.result   (res)
	);

	assign flight_phase   = res.flight_phase;
	assign drogue_pyro    = res.drogue_pyro;
	assign main_pyro      = res.main_pyro;
	assign phase_changed  = res.phase_changed;
	assign peak_height_cm = res.peak_height_cm;

`ifndef ASSERT_OFF
	a_midq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (MIDQ_AW+2)'(MIDQ_DEPTH))
		else $error("middle queue over capacity");

	a_midq_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(midq_cnt == (MIDQ_AW+1)'(MIDQ_DEPTH)) |-> full)
		else $error("full low with middle queue at depth");

	a_no_drogue_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (DUAL_DEPLOY || !drogue_pyro))
		else $error("drogue pyro in single deployment");
`endif

endmodule
